// ----- design/b58d_pkg.sv -----
package b58d_pkg;

    localparam int MAX_BYTES_DEF = 64;
    localparam logic [6:0] OUT_SIZE_RST = 7'd25;
    localparam logic [6:0] ONES_MAX = 7'd127;
    localparam logic [7:0] CHAR_ONE = 8'h31;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ONES     = 2'd3
    } status_t;

    // Queue entry passed from the classifier to the arithmetic engine.
    typedef struct packed {
        logic       is_one;   // leading '1' inside the leading run
        logic       valid_d;  // character maps to a digit
        logic [5:0] digit;
        logic       last;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FOLD,
        BK_SCAN,
        BK_EMIT,
        BK_CLEAR
    } bk_state_t;

    // Base58 digit value of a character; bit 6 set when not in the alphabet.
    function automatic logic [6:0] char_digit(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'h40;
        if (ch >= 8'h31 && ch <= 8'h39) r = 7'(ch - 8'h31);
        else if (ch >= 8'h41 && ch <= 8'h48) r = 7'(ch - 8'h41 + 8'd9);
        else if (ch >= 8'h4a && ch <= 8'h4e) r = 7'(ch - 8'h4a + 8'd17);
        else if (ch >= 8'h50 && ch <= 8'h5a) r = 7'(ch - 8'h50 + 8'd22);
        else if (ch >= 8'h61 && ch <= 8'h6b) r = 7'(ch - 8'h61 + 8'd33);
        else if (ch >= 8'h6d && ch <= 8'h7a) r = 7'(ch - 8'h6d + 8'd44);
        return r;
    endfunction

endpackage

// ----- design/base58_decoder.sv -----
// Channel  | Direction | Signals
// s_       | in        | s_valid, s_ready, s_digit_char, s_last_char
// m_       | out       | m_valid, m_ready, m_out_byte, m_last_out, m_decoded_length, m_status
// cfg_     | in        | cfg_valid, cfg_ready, cfg_data (out_size)
//
// A character inside the leading run of '1's, an invalid one, or one that
// follows an error does not touch the accumulator. Any other character folds
// into the accumulator memory one byte at a time over all MAX_BYTES bytes
// (read, then multiply-add and write-back).
// The final character adds, when no error is pending, a scan of out_size bytes
// (clamped to 1..MAX_BYTES), then the result transactions, which wait while
// m_ready is low; with an error pending, a single error transaction instead.
// Then a pass clears the accumulator. After reset the same clearing pass runs
// before the engine takes its first character. A two-entry queue lets the
// classifier accept while the engine is busy.
module base58_decoder #(
    parameter int MAX_BYTES = b58d_pkg::MAX_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_digit_char,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_out,
    output logic [6:0] m_decoded_length,
    output logic [1:0] m_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    logic [6:0]     out_size_reg;
    logic           q_valid, q_ready;
    b58d_pkg::cmd_t q_cmd;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_size_reg <= b58d_pkg::OUT_SIZE_RST;
        end else if (cfg_valid) begin
            out_size_reg <= cfg_data;
        end
    end

    b58d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_digit_char (s_digit_char),
        .s_last_char  (s_last_char),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd)
    );

    b58d_back #(.MAX_BYTES(MAX_BYTES)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .out_size         (out_size_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_cmd            (q_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_out       (m_last_out),
        .m_decoded_length (m_decoded_length),
        .m_status         (m_status)
    );

    // An error transaction is always the only and final one of its string.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != b58d_pkg::ST_OK |-> m_last_out && m_out_byte == 8'd0)
        else $error("error transaction not final");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && !m_ready) |-> m_valid && $stable(m_out_byte))
        else $error("result changed while stalled");

    // An error transaction carries a length of zero.
    a_err_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != b58d_pkg::ST_OK |-> m_decoded_length == 7'd0)
        else $error("error transaction with length");

endmodule

// ----- design/b58d_ram.sv -----
module b58d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/b58d_front.sv -----
module b58d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_digit_char,
    input  logic                s_last_char,
    output logic                q_valid,
    input  logic                q_ready,
    output b58d_pkg::cmd_t      q_cmd
);

    // Two-entry queue; classification happens on the way in.
    b58d_pkg::cmd_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       run_reg;
    logic [6:0] dg;
    logic       push, pop;
    b58d_pkg::cmd_t c;

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rd_reg];

    always_comb begin
        dg = b58d_pkg::char_digit(s_digit_char);
        c.is_one = run_reg && (s_digit_char == b58d_pkg::CHAR_ONE);
        c.valid_d = !dg[6];
        c.digit = dg[5:0];
        c.last = s_last_char;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            run_reg <= 1'b1;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= !wr_reg;
                run_reg <= s_last_char ? 1'b1 : c.is_one;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
        end
        if (push) begin
            mem_reg[wr_reg] <= c;
        end
    end

endmodule

// ----- design/b58d_back.sv -----
module b58d_back #(
    parameter int MAX_BYTES = b58d_pkg::MAX_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [6:0]     out_size,
    input  logic           q_valid,
    output logic           q_ready,
    input  b58d_pkg::cmd_t q_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_out,
    output logic [6:0]     m_decoded_length,
    output logic [1:0]     m_status
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int RD = (MAX_BYTES > 1) ? MAX_BYTES : 2;

    b58d_pkg::bk_state_t state_reg, state_next;
    b58d_pkg::cmd_t      cmd_reg, cmd_next;
    logic [AW:0]  idx_reg, idx_next;
    logic [7:0]   carry_reg, carry_next;
    logic         high_reg, high_next;
    logic         lead_reg, lead_next;     // all bytes so far in scan were zero
    logic [6:0]   zeros_reg, zeros_next;
    logic [6:0]   ones_reg, ones_next;
    logic [1:0]   err_reg, err_next;
    logic [6:0]   n_reg, n_next;
    logic [6:0]   len_reg, len_next;
    logic         rpend_reg, rpend_next;   // read data valid for idx_reg

    logic         ob_valid_reg, ob_valid_next;
    logic [7:0]   ob_byte_reg, ob_byte_next;
    logic         ob_last_reg, ob_last_next;
    logic [6:0]   ob_len_reg, ob_len_next;
    logic [1:0]   ob_st_reg, ob_st_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic [13:0]   prod;
    logic [6:0]    nsz;

    b58d_ram #(.WIDTH(8), .DEPTH(RD)) u_acc (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_valid = ob_valid_reg;
    assign m_out_byte = ob_byte_reg;
    assign m_last_out = ob_last_reg;
    assign m_decoded_length = ob_len_reg;
    assign m_status = ob_st_reg;
    assign prod = {6'd0, rdata} * 14'd58 + {6'd0, carry_reg};

    always_comb begin
        nsz = out_size;
        if (nsz == 7'd0) nsz = 7'd1;
        if (nsz > 7'(MAX_BYTES)) nsz = 7'(MAX_BYTES);
    end

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        carry_next = carry_reg;
        high_next = high_reg;
        lead_next = lead_reg;
        zeros_next = zeros_reg;
        ones_next = ones_reg;
        err_next = err_reg;
        n_next = n_reg;
        len_next = len_reg;
        rpend_next = 1'b0;
        ob_valid_next = ob_valid_reg && !m_ready;
        ob_byte_next = ob_byte_reg;
        ob_last_next = ob_last_reg;
        ob_len_next = ob_len_reg;
        ob_st_next = ob_st_reg;
        q_ready = 1'b0;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = '0;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            b58d_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                n_next = nsz;
                if (q_valid) begin
                    cmd_next = q_cmd;
                    idx_next = '0;
                    if (q_cmd.is_one) begin
                        if (ones_reg != b58d_pkg::ONES_MAX) ones_next = ones_reg + 7'd1;
                        state_next = q_cmd.last ? b58d_pkg::BK_SCAN : b58d_pkg::BK_IDLE;
                    end else if (err_reg != b58d_pkg::ST_OK) begin
                        state_next = q_cmd.last ? b58d_pkg::BK_SCAN : b58d_pkg::BK_IDLE;
                    end else if (!q_cmd.valid_d) begin
                        err_next = b58d_pkg::ST_INVALID;
                        state_next = q_cmd.last ? b58d_pkg::BK_SCAN : b58d_pkg::BK_IDLE;
                    end else begin
                        carry_next = {2'b00, q_cmd.digit};
                        high_next = 1'b0;
                        state_next = b58d_pkg::BK_FOLD;
                    end
                    if (q_cmd.last) begin
                        idx_next = {1'b0, AW'(nsz - 7'd1)};
                        zeros_next = '0;
                        lead_next = 1'b1;
                    end
                    if (state_next == b58d_pkg::BK_FOLD) idx_next = '0;
                end
            end
            b58d_pkg::BK_FOLD: begin
                // Each byte is read, then multiplied-added and written back.
                if (!rpend_reg) begin
                    rpend_next = 1'b1;
                end else begin
                    we = 1'b1;
                    wdata = prod[7:0];
                    carry_next = {2'b00, prod[13:8]};
                    if ({1'b0, idx_reg} >= {1'b0, n_reg} && prod[7:0] != 8'd0)
                        high_next = 1'b1;
                    if (idx_reg == (AW+1)'(MAX_BYTES - 1)) begin
                        if (prod[13:8] != 6'd0 || high_next) err_next = b58d_pkg::ST_OVERFLOW;
                        if (cmd_reg.last) begin
                            idx_next = {1'b0, AW'(n_reg - 7'd1)};
                            zeros_next = '0;
                            lead_next = 1'b1;
                            state_next = b58d_pkg::BK_SCAN;
                        end else begin
                            state_next = b58d_pkg::BK_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + (AW+1)'(1);
                    end
                end
            end
            b58d_pkg::BK_SCAN: begin
                // Count leading zero bytes from the top down, or emit the pending error.
                if (err_reg != b58d_pkg::ST_OK) begin
                    if (!ob_valid_next) begin
                        ob_valid_next = 1'b1;
                        ob_byte_next = '0;
                        ob_last_next = 1'b1;
                        ob_len_next = '0;
                        ob_st_next = err_reg;
                        idx_next = '0;
                        state_next = b58d_pkg::BK_CLEAR;
                    end
                end else if (!rpend_reg) begin
                    rpend_next = 1'b1;
                end else begin
                    if (lead_reg && rdata == 8'd0) zeros_next = zeros_reg + 7'd1;
                    else lead_next = 1'b0;
                    if (idx_reg == '0) begin
                        if (lead_reg && rdata == 8'd0) begin
                            len_next = ones_reg;
                        end else begin
                            len_next = n_reg - zeros_next + ones_reg;
                            if (ones_reg > zeros_next) err_next = b58d_pkg::ST_ONES;
                        end
                        idx_next = {1'b0, AW'(n_reg - 7'd1)};
                        state_next = b58d_pkg::BK_EMIT;
                    end else begin
                        idx_next = idx_reg - (AW+1)'(1);
                    end
                end
            end
            b58d_pkg::BK_EMIT: begin
                if (err_reg != b58d_pkg::ST_OK) begin
                    state_next = b58d_pkg::BK_SCAN;
                end else if (!rpend_reg) begin
                    rpend_next = 1'b1;
                end else if (!ob_valid_next) begin
                    ob_valid_next = 1'b1;
                    ob_byte_next = rdata;
                    ob_last_next = (idx_reg == '0);
                    ob_len_next = len_reg;
                    ob_st_next = b58d_pkg::ST_OK;
                    if (idx_reg == '0) begin
                        state_next = b58d_pkg::BK_CLEAR;
                    end else begin
                        idx_next = idx_reg - (AW+1)'(1);
                    end
                end else begin
                    rpend_next = 1'b1;
                end
            end
            b58d_pkg::BK_CLEAR: begin
                we = 1'b1;
                wdata = '0;
                if (idx_reg == (AW+1)'(MAX_BYTES - 1)) begin
                    ones_next = '0;
                    err_next = b58d_pkg::ST_OK;
                    state_next = b58d_pkg::BK_IDLE;
                end else begin
                    idx_next = idx_reg + (AW+1)'(1);
                end
            end
            default: state_next = b58d_pkg::BK_IDLE;
        endcase
        if (state_reg == b58d_pkg::BK_EMIT && state_next == b58d_pkg::BK_CLEAR) idx_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b58d_pkg::BK_CLEAR;
            idx_reg <= '0;
            ones_reg <= '0;
            err_reg <= b58d_pkg::ST_OK;
            rpend_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ones_reg <= ones_next;
            err_reg <= err_next;
            rpend_reg <= rpend_next;
            ob_valid_reg <= ob_valid_next;
        end
        cmd_reg <= cmd_next;
        carry_reg <= carry_next;
        high_reg <= high_next;
        lead_reg <= lead_next;
        zeros_reg <= zeros_next;
        n_reg <= n_next;
        len_reg <= len_next;
        ob_byte_reg <= ob_byte_next;
        ob_last_reg <= ob_last_next;
        ob_len_reg <= ob_len_next;
        ob_st_reg <= ob_st_next;
    end

endmodule

// ----- sim/base58_decoder_tb.sv -----
module base58_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The alphabet maps position to digit value: '1' is 0, 'z' is 57.
    localparam string ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam int RADIX = 58;
    localparam int MAXB = b58d_pkg::MAX_BYTES_DEF;
    // After the last expected transaction the block may still be folding a
    // character and then clearing its accumulator, so idle waits cover that.
    localparam int SETTLE_CYCLES = 4 * MAXB + 64;
    // Longest stretch without any accepted transaction before giving up.
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2000;
    localparam int ITEMS_PER_PHASE = 30;

    // One decoded output byte, as the result channel should present it.
    typedef struct {
        logic [7:0]        out_byte;
        logic              last_out;
        logic [6:0]        decoded_length;
        b58d_pkg::status_t status;
    } byte_result_t;

    // Directed stimulus row: the register setting the row needs, the
    // character, and, where it is obvious, the single error transaction.
    typedef struct {
        logic [6:0]        size;
        logic [7:0]        ch;
        logic              last;
        bit                typed;
        b58d_pkg::status_t err;
    } char_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_digit_char;
    logic       s_last_char;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_last_out;
    logic [6:0] m_decoded_length;
    logic [1:0] m_status;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    base58_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_digit_char     (s_digit_char),
        .s_last_char      (s_last_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_out       (m_last_out),
        .m_decoded_length (m_decoded_length),
        .m_status         (m_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow copy of the decoder state, updated on every accepted character.
    logic [7:0]        shadow_acc [MAXB];
    logic [6:0]        shadow_ones;
    bit                shadow_in_run;
    b58d_pkg::status_t shadow_err;
    logic [6:0]        shadow_size;

    byte_result_t pending_bytes[$];
    int         fail_count;
    int         idle_send_pct;
    int         idle_recv_pct;
    int         hold_request;
    int         hold_seen;
    int         hold_left;
    int         quiet_cycles;
    int         phase_items;

    function automatic void clear_shadow();
        foreach (shadow_acc[i]) shadow_acc[i] = 8'h00;
        shadow_ones = 7'd0;
        shadow_in_run = 1'b1;
        shadow_err = b58d_pkg::ST_OK;
    endfunction

    // Digit value of a character, or -1 when it is not in the alphabet.
    function automatic int digit_value(logic [7:0] ch);
        if (ch[7]) return -1;
        for (int k = 0; k < RADIX; k++) begin
            if (ALPHABET[k] == ch) return k;
        end
        return -1;
    endfunction

    // Advances the shadow state by one character and, on the last one of a
    // string, queues the transactions the decoder must produce.
    task automatic decode_char(logic [7:0] ch, logic last, bit typed,
                               b58d_pkg::status_t err);
        int n;
        int d;
        int carry;
        int t;
        int zeros;
        bit high;
        logic [6:0] len;
        byte_result_t r;
        n = (shadow_size == 0) ? 1 : (shadow_size > MAXB) ? MAXB : shadow_size;
        if (shadow_in_run && ch == b58d_pkg::CHAR_ONE) begin
            if (shadow_ones < b58d_pkg::ONES_MAX) shadow_ones++;
        end else begin
            shadow_in_run = 1'b0;
            if (shadow_err == b58d_pkg::ST_OK) begin
                d = digit_value(ch);
                if (d < 0) begin
                    shadow_err = b58d_pkg::ST_INVALID;
                end else begin
                    // The overflow test looks at the whole accumulator, not
                    // just the bytes of the current output size.
                    carry = d;
                    high = 1'b0;
                    for (int i = 0; i < MAXB; i++) begin
                        t = shadow_acc[i] * RADIX + carry;
                        shadow_acc[i] = t[7:0];
                        carry = t >> 8;
                        if (i >= n && shadow_acc[i] != 0) high = 1'b1;
                    end
                    if (carry != 0 || high) shadow_err = b58d_pkg::ST_OVERFLOW;
                end
            end
        end
        if (!last) return;
        zeros = 0;
        if (shadow_err == b58d_pkg::ST_OK) begin
            while (zeros < n && shadow_acc[n - 1 - zeros] == 0) zeros++;
            // Leading ones must be matched by zero bytes, unless all are zero.
            if (zeros < n && shadow_ones > zeros) shadow_err = b58d_pkg::ST_ONES;
        end
        if (typed || shadow_err != b58d_pkg::ST_OK) begin
            r.out_byte = 8'h00;
            r.last_out = 1'b1;
            r.decoded_length = 7'd0;
            r.status = typed ? err : shadow_err;
            pending_bytes.push_back(r);
        end else begin
            len = 7'(n - zeros + shadow_ones);
            for (int i = 0; i < n; i++) begin
                r.out_byte = shadow_acc[n - 1 - i];
                r.last_out = (i == n - 1);
                r.decoded_length = len;
                r.status = b58d_pkg::ST_OK;
                pending_bytes.push_back(r);
            end
        end
        clear_shadow();
    endtask

    // Offers one character and waits until the decoder takes it. It is
    // called at a rising edge and returns at the edge of acceptance.
    task automatic send_char(logic [7:0] ch, logic last, bit typed,
                             b58d_pkg::status_t err);
        while ($urandom_range(99) < idle_send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_digit_char <= ch;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        decode_char(ch, last, typed, err);
        phase_items++;
    endtask

    // Registers change only with the decoder idle: every expected transaction
    // has come out and any trailing fold or clearing pass has finished.
    task automatic write_size(logic [6:0] value);
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_size = value;
    endtask

    // A mostly well-formed string: a run of ones, then alphabet characters
    // of a length near what the output size can hold, so some overflow.
    // Now and then a string is broken with arbitrary bytes.
    task automatic send_string(int n);
        int ones;
        int len;
        int r;
        bit broken;
        logic [7:0] ch;
        r = $urandom_range(99);
        ones = (r < 70) ? $urandom_range(0, 2) : (r < 95) ? $urandom_range(3, 6) : 130;
        len = $urandom_range(1, (n * 14) / 10 + 2);
        broken = ($urandom_range(9) == 0);
        for (int i = 0; i < ones + len; i++) begin
            if (i < ones) begin
                ch = b58d_pkg::CHAR_ONE;
            end else if (broken && $urandom_range(3) == 0) begin
                ch = 8'($urandom_range(255));
            end else begin
                ch = ALPHABET[$urandom_range(RADIX - 1)];
            end
            send_char(ch, i == ones + len - 1, 1'b0, b58d_pkg::ST_OK);
        end
    endtask

    // Result side: random back-pressure, a long hold-off on request, and the
    // comparison of each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        byte_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected result transaction: out_byte %0h", m_out_byte);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, m_out_byte);
                        fail_count++;
                    end
                    if (m_last_out !== want.last_out) begin
                        $error("last_out: expected %0b, got %0b", want.last_out, m_last_out);
                        fail_count++;
                    end
                    if (m_decoded_length !== want.decoded_length) begin
                        $error("decoded_length: expected %0d, got %0d",
                               want.decoded_length, m_decoded_length);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                end
            end
            if (hold_request != hold_seen) begin
                hold_seen <= hold_request;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_recv_pct);
            end
        end
    end

    // Watchdog: any accepted transaction on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    char_row_t directed_rows[] = '{
        // At the reset size of 25 bytes.
        '{7'd25, b58d_pkg::CHAR_ONE, 1'b1, 1'b0, b58d_pkg::ST_OK},  // all zero, length from ones
        '{7'd25, "2",      1'b1, 1'b0, b58d_pkg::ST_OK},
        '{7'd25, "z",      1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd25, "z",      1'b1, 1'b0, b58d_pkg::ST_OK},
        // One output byte: error codes and the edges of the value range.
        '{7'd1,  "0",      1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  "l",      1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  8'hff,    1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  8'h80,    1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  8'h00,    1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  "z",      1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "z",      1'b1, 1'b1, b58d_pkg::ST_OVERFLOW},
        '{7'd1,  "5",      1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "Q",      1'b1, 1'b0, b58d_pkg::ST_OK},   // 255, the largest one-byte value
        '{7'd1,  b58d_pkg::CHAR_ONE, 1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  b58d_pkg::CHAR_ONE, 1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "2",      1'b1, 1'b1, b58d_pkg::ST_ONES},
        // The first error wins over later characters.
        '{7'd1,  "0",      1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "z",      1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "z",      1'b1, 1'b1, b58d_pkg::ST_INVALID},
        '{7'd1,  b58d_pkg::CHAR_ONE, 1'b0, 1'b0, b58d_pkg::ST_OK},
        '{7'd1,  "1",      1'b1, 1'b0, b58d_pkg::ST_OK}
    };

    logic [6:0] phase_sizes[] = '{7'd1, 7'd64, 7'd8, 7'd0, 7'd127, 7'd25, 7'd3, 7'd1};

    initial begin
        int n;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_digit_char = 8'h00;
        s_last_char = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = b58d_pkg::OUT_SIZE_RST;
        fail_count = 0;
        hold_request = 0;
        hold_seen = 0;
        hold_left = 0;
        quiet_cycles = 0;
        phase_items = 0;
        idle_send_pct = 11;
        idle_recv_pct = 78;
        shadow_size = b58d_pkg::OUT_SIZE_RST;
        clear_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].size != shadow_size) write_size(directed_rows[i].size);
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].err);
        end

        foreach (phase_sizes[p]) begin
            // Sender idles lightly first, then heavily, then neither side idles.
            idle_send_pct = (p < 3) ? 11 : (p < 6) ? 78 : 0;
            idle_recv_pct = (p < 3) ? 78 : (p < 6) ? 11 : 0;
            write_size(phase_sizes[p]);
            n = (shadow_size == 0) ? 1 : (shadow_size > MAXB) ? MAXB : shadow_size;
            // Hold off the result side for a long stretch while characters
            // keep coming, so the input queue fills and stalls.
            if (p == 4) hold_request++;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) send_string(n);
        end

        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
